@@ rtl/core/clcd_pkg.sv @@
// ----------------------------------------------------------------------------
// clcd_pkg
// Types, codes and helpers shared by the character LCD request sequencer.
// ----------------------------------------------------------------------------
package clcd_pkg;

	// Request operation codes
	localparam logic [2:0] OP_COMMAND = 3'd0;
	localparam logic [2:0] OP_CHAR    = 3'd1;
	localparam logic [2:0] OP_CURSOR  = 3'd2;
	localparam logic [2:0] OP_CLEAR   = 3'd3;
	localparam logic [2:0] OP_HOME    = 3'd4;
	localparam logic [2:0] OP_NUMBER  = 3'd5;
	localparam logic [2:0] OP_INIT    = 3'd6;

	// Configuration register indexes
	localparam logic [2:0] REG_COMMAND_WAIT = 3'd0;
	localparam logic [2:0] REG_CLEAR_EXTRA  = 3'd1;
	localparam logic [2:0] REG_POWER_UP     = 3'd2;
	localparam logic [2:0] REG_INIT_LONG    = 3'd3;
	localparam logic [2:0] REG_INIT_SHORT   = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 20;

	// Reset values of the registers
	localparam logic [15:0] COMMAND_WAIT_RST = 16'd2000;
	localparam logic [15:0] CLEAR_EXTRA_RST  = 16'd2000;
	localparam logic [19:0] POWER_UP_RST     = 20'd300000;
	localparam logic [15:0] INIT_LONG_RST    = 16'd5000;
	localparam logic [15:0] INIT_SHORT_RST   = 16'd200;

	localparam int MAX_COLUMN_DEF = 15;

	// Queued job kinds
	localparam logic [1:0] JOB_BYTE   = 2'd0;
	localparam logic [1:0] JOB_NUMBER = 2'd1;
	localparam logic [1:0] JOB_INIT   = 2'd2;

	// Fixed command bytes and characters
	localparam logic [7:0] CMD_CLEAR   = 8'h01;
	localparam logic [7:0] CMD_HOME    = 8'h02;
	localparam logic [7:0] CMD_DDRAM   = 8'h80;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_MINUS  = 8'h2D;
	localparam logic [3:0] NIB_WAKE    = 4'h3;
	localparam logic [3:0] NIB_4BIT    = 4'h2;

	localparam int NUM_DIGITS = 10;
	localparam int BCD_W      = 4 * NUM_DIGITS;
	localparam int MAG_W      = 32;

	// Init sequence: four raw nibbles, then four bytes (eight nibbles)
	localparam logic [3:0] INIT_RAW_STEPS = 4'd4;
	localparam logic [3:0] INIT_LAST_STEP = 4'd11;

	localparam int Q_DEPTH = 2;

	typedef struct packed {
		logic [2:0]        operation;
		logic [7:0]        byte_value;
		logic [7:0]        row;
		logic [7:0]        col;
		logic signed [31:0] number;
	} in_item_t;

	typedef struct packed {
		logic        reg_select;
		logic [3:0]  nibble;
		logic [19:0] wait_before_us;
		logic [16:0] wait_after_us;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [15:0] command_wait_us;
		logic [15:0] clear_extra_wait_us;
		logic [19:0] power_up_wait_us;
		logic [15:0] init_long_wait_us;
		logic [15:0] init_short_wait_us;
	} cfg_regs_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic             rs;
		logic             slow;
		logic [7:0]       byte_val;
		logic             neg;
		logic [3:0]       dig_hi;
		logic [BCD_W-1:0] bcd;
	} job_t;

	// One double-dabble correction: add 3 to every digit of 5 or more
	function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] v);
		logic [BCD_W-1:0] r;
		r = v;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (v[4*i +: 4] >= 4'd5) begin
				r[4*i +: 4] = v[4*i +: 4] + 4'd3;
			end
		end
		return r;
	endfunction

	// Index of the most significant nonzero digit, zero for a zero value
	function automatic logic [3:0] top_digit(input logic [BCD_W-1:0] v);
		logic [3:0] r;
		r = 4'd0;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (v[4*i +: 4] != 4'd0) begin
				r = 4'(i);
			end
		end
		return r;
	endfunction

	// Command bytes that follow the raw wake-up nibbles of the init sequence
	function automatic logic [7:0] init_byte(input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0:    r = 8'h28;
			2'd1:    r = 8'h0C;
			2'd2:    r = 8'h06;
			default: r = CMD_CLEAR;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/core/clcd_front.sv @@
// ----------------------------------------------------------------------------
// clcd_front
// Accepts requests, turns them into queued jobs; converts numbers to BCD.
// ----------------------------------------------------------------------------
module clcd_front #(
	parameter int MAX_COLUMN = clcd_pkg::MAX_COLUMN_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  clcd_pkg::in_item_t in_item,
	output logic               push,
	output clcd_pkg::job_t     push_job,
	input  logic               q_full
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_PUSH = 2'd2;
	localparam logic [4:0] LAST_SHIFT = 5'(clcd_pkg::MAG_W - 1);

	logic [1:0]                 state_q;
	logic [4:0]                 cnt_q;
	logic [clcd_pkg::MAG_W-1:0] sh_q;
	logic [clcd_pkg::BCD_W-1:0] bcd_q;
	logic                       neg_q;

	logic                       accept;
	logic                       is_number;
	logic [7:0]                 row_c;
	logic [7:0]                 col_c;
	logic [7:0]                 cursor_byte;
	logic [clcd_pkg::BCD_W-1:0] bcd_adj;
	clcd_pkg::job_t             req_job;
	logic                       req_push;

	assign in_stall  = (state_q != S_IDLE) || q_full;
	assign accept    = in_valid && !in_stall;
	assign is_number = (in_item.operation == clcd_pkg::OP_NUMBER);

	assign row_c = (in_item.row > 8'd1) ? 8'd1 : in_item.row;
	assign col_c = (in_item.col > 8'(MAX_COLUMN)) ? 8'(MAX_COLUMN) : in_item.col;
	assign cursor_byte = clcd_pkg::CMD_DDRAM | {1'b0, row_c[0], 6'd0} | {1'b0, col_c[6:0]};
	assign bcd_adj = clcd_pkg::bcd_adjust(bcd_q);

	// Classify a direct request
	always_comb begin
		req_job          = '0;
		req_job.kind     = clcd_pkg::JOB_BYTE;
		req_push         = 1'b1;
		case (in_item.operation)
			clcd_pkg::OP_COMMAND: begin
				req_job.byte_val = in_item.byte_value;
			end
			clcd_pkg::OP_CHAR: begin
				req_job.rs       = 1'b1;
				req_job.byte_val = in_item.byte_value;
			end
			clcd_pkg::OP_CURSOR: begin
				req_job.byte_val = cursor_byte;
			end
			clcd_pkg::OP_CLEAR: begin
				req_job.byte_val = clcd_pkg::CMD_CLEAR;
				req_job.slow     = 1'b1;
			end
			clcd_pkg::OP_HOME: begin
				req_job.byte_val = clcd_pkg::CMD_HOME;
				req_job.slow     = 1'b1;
			end
			clcd_pkg::OP_INIT: begin
				req_job.kind = clcd_pkg::JOB_INIT;
			end
			default: begin
				req_push = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (state_q == S_PUSH) begin
			push            = !q_full;
			push_job        = '0;
			push_job.kind   = clcd_pkg::JOB_NUMBER;
			push_job.rs     = 1'b1;
			push_job.neg    = neg_q;
			push_job.dig_hi = clcd_pkg::top_digit(bcd_q);
			push_job.bcd    = bcd_q;
		end else begin
			push     = accept && req_push;
			push_job = req_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && is_number) begin
						state_q <= S_CONV;
						cnt_q   <= '0;
					end
				end
				S_CONV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == LAST_SHIFT) begin
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (!q_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Shift-add-3 conversion, one magnitude bit per cycle
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept && is_number) begin
			neg_q <= in_item.number[31];
			sh_q  <= in_item.number[31] ? (32'd0 - unsigned'(in_item.number))
			                            : unsigned'(in_item.number);
			bcd_q <= '0;
		end else if (state_q == S_CONV) begin
			sh_q  <= {sh_q[clcd_pkg::MAG_W-2:0], 1'b0};
			bcd_q <= {bcd_adj[clcd_pkg::BCD_W-2:0], sh_q[clcd_pkg::MAG_W-1]};
		end
	end

endmodule

@@ rtl/core/clcd_fifo.sv @@
// ----------------------------------------------------------------------------
// clcd_fifo
// Short job queue between the request front and the nibble back end.
// ----------------------------------------------------------------------------
module clcd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clcd_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output clcd_pkg::job_t head
);

	localparam int PTR_W = $clog2(clcd_pkg::Q_DEPTH);
	localparam int CNT_W = $clog2(clcd_pkg::Q_DEPTH + 1);

	clcd_pkg::job_t     slot_q [clcd_pkg::Q_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(clcd_pkg::Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == PTR_W'(clcd_pkg::Q_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTR_W'(clcd_pkg::Q_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push && !full) - CNT_W'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

@@ rtl/core/clcd_back.sv @@
// ----------------------------------------------------------------------------
// clcd_back
// Walks the head job one nibble per beat into the output register.
// ----------------------------------------------------------------------------
module clcd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  clcd_pkg::cfg_regs_t cfg,
	input  logic                head_valid,
	input  clcd_pkg::job_t      head,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output clcd_pkg::out_item_t out_item
);

	logic                started_q;
	logic                half_q;
	logic                minus_q;
	logic [3:0]          dig_q;
	logic [3:0]          step_q;
	logic                out_valid_q;
	clcd_pkg::out_item_t out_q;

	logic                cur_half;
	logic                cur_minus;
	logic [3:0]          cur_dig;
	logic [3:0]          cur_step;
	logic [3:0]          step_off;
	logic [3:0]          digit;
	logic [7:0]          byte_v;
	logic                half_sel;
	logic                slow;
	logic                rs;
	logic                raw;
	clcd_pkg::out_item_t nib;
	logic                adv;

	assign cur_half  = started_q ? half_q  : 1'b0;
	assign cur_minus = started_q ? minus_q : head.neg;
	assign cur_dig   = started_q ? dig_q   : head.dig_hi;
	assign cur_step  = started_q ? step_q  : 4'd0;
	assign step_off  = cur_step - clcd_pkg::INIT_RAW_STEPS;
	assign digit     = head.bcd[4*cur_dig +: 4];

	assign adv = head_valid && (!out_valid_q || !out_stall);
	assign pop = adv && nib.last;

	always_comb begin
		byte_v   = head.byte_val;
		half_sel = cur_half;
		slow     = head.slow;
		rs       = head.rs;
		raw      = 1'b0;
		nib      = '0;
		case (head.kind)
			clcd_pkg::JOB_NUMBER: begin
				byte_v   = cur_minus ? clcd_pkg::CHAR_MINUS : (clcd_pkg::CHAR_ZERO | {4'd0, digit});
				slow     = 1'b0;
				rs       = 1'b1;
				nib.last = cur_half && !cur_minus && (cur_dig == 4'd0);
			end
			clcd_pkg::JOB_INIT: begin
				rs       = 1'b0;
				raw      = (cur_step < clcd_pkg::INIT_RAW_STEPS);
				byte_v   = clcd_pkg::init_byte(step_off[2:1]);
				half_sel = step_off[0];
				slow     = (step_off[2:1] == 2'd3);
				nib.last = (cur_step == clcd_pkg::INIT_LAST_STEP);
			end
			default: begin
				nib.last = cur_half;
			end
		endcase

		nib.reg_select = rs;
		if (raw) begin
			// Wake-up nibbles: 3, 3, 3, then 2 to enter 4-bit mode
			nib.nibble = (cur_step == 4'd3) ? clcd_pkg::NIB_4BIT : clcd_pkg::NIB_WAKE;
			nib.wait_before_us = (cur_step == 4'd0) ? cfg.power_up_wait_us : 20'd0;
			nib.wait_after_us = (cur_step == 4'd0 || cur_step == 4'd3)
			                    ? {1'b0, cfg.init_long_wait_us}
			                    : {1'b0, cfg.init_short_wait_us};
		end else begin
			nib.nibble = half_sel ? byte_v[3:0] : byte_v[7:4];
			nib.wait_before_us = 20'd0;
			nib.wait_after_us = half_sel
			                    ? ({1'b0, cfg.command_wait_us}
			                       + (slow ? {1'b0, cfg.clear_extra_wait_us} : 17'd0))
			                    : 17'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				started_q   <= !nib.last;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q  <= nib;
			half_q <= !cur_half;
			step_q <= cur_step + 4'd1;
			if (cur_half && cur_minus) begin
				minus_q <= 1'b0;
				dig_q   <= cur_dig;
			end else if (cur_half) begin
				minus_q <= 1'b0;
				dig_q   <= cur_dig - 4'd1;
			end else begin
				minus_q <= cur_minus;
				dig_q   <= cur_dig;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

@@ rtl/core/char_lcd_4bit_request_sequencer.sv @@
// ----------------------------------------------------------------------------
// char_lcd_4bit_request_sequencer
// Turns LCD requests into runs of 4-bit nibble transfers with their waits.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | beat taken when
//  --------+----------------------------------+------------------------------
//  request | in_valid, in_stall, in_item      | in_valid && !in_stall
//  nibble  | out_valid, out_stall, out_item   | out_valid && !out_stall
//  config  | cfg_we, cfg_index, cfg_data      | cfg_we
//
//  A byte, cursor, clear, home or init request enters the job queue in the
//  cycle it is taken. A number request holds the request side in the front
//  end while a shift-add-3 unit builds its digits (one magnitude bit per
//  cycle). The back end emits one nibble per cycle from the queue head while
//  out_stall is low; a request becomes 2 to 22 nibbles. No clearing pass after
//  reset; the queue and output register are empty once arst_n is released.
//  Either side may stall independently; the two-entry queue decouples them.
//
module char_lcd_4bit_request_sequencer #(
	parameter int MAX_COLUMN = clcd_pkg::MAX_COLUMN_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  clcd_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output clcd_pkg::out_item_t                out_item,
	input  logic                               cfg_we,
	input  logic [clcd_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [clcd_pkg::CFG_DATA_W-1:0]    cfg_data
);

	clcd_pkg::cfg_regs_t cfg_q;
	logic                push;
	clcd_pkg::job_t      push_job;
	logic                q_full;
	logic                pop;
	logic                head_valid;
	clcd_pkg::job_t      head;

	// Register file: drop bits above each register's width, ignore stray indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.command_wait_us     <= clcd_pkg::COMMAND_WAIT_RST;
			cfg_q.clear_extra_wait_us <= clcd_pkg::CLEAR_EXTRA_RST;
			cfg_q.power_up_wait_us    <= clcd_pkg::POWER_UP_RST;
			cfg_q.init_long_wait_us   <= clcd_pkg::INIT_LONG_RST;
			cfg_q.init_short_wait_us  <= clcd_pkg::INIT_SHORT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				clcd_pkg::REG_COMMAND_WAIT: cfg_q.command_wait_us     <= cfg_data[15:0];
				clcd_pkg::REG_CLEAR_EXTRA:  cfg_q.clear_extra_wait_us <= cfg_data[15:0];
				clcd_pkg::REG_POWER_UP:     cfg_q.power_up_wait_us    <= cfg_data;
				clcd_pkg::REG_INIT_LONG:    cfg_q.init_long_wait_us   <= cfg_data[15:0];
				clcd_pkg::REG_INIT_SHORT:   cfg_q.init_short_wait_us  <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// Front: classify requests, convert numbers, push jobs
	clcd_front #(
		.MAX_COLUMN(MAX_COLUMN)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	// Queue: hold jobs until the back end is free
	clcd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// Back: advance one nibble per beat, drop the job on its last nibble
	clcd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

endmodule

@@ rtl/core/clcd_checker.sv @@
// ----------------------------------------------------------------------------
// clcd_checker
// Port-level checks for the LCD request sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module clcd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input clcd_pkg::out_item_t out_item
);

	// Hold a stalled nibble beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled nibble beat changed");

	// Only the first init wake-up nibble carries a wait before it
	a_wait_before_wake: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.wait_before_us != 20'd0) |->
		!out_item.reg_select && (out_item.nibble == clcd_pkg::NIB_WAKE))
		else $error("wait before strobe on a non-wake nibble");

	// The power-up nibble opens a long run and is never the last one
	a_wait_before_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.wait_before_us != 20'd0) |-> !out_item.last)
		else $error("power-up nibble marked last");

	// Handshake outputs are always driven to a known level out of reset
	a_known_handshake: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({in_stall, out_valid}))
		else $error("unknown level on in_stall or out_valid");

endmodule

bind char_lcd_4bit_request_sequencer clcd_checker u_clcd_checker (.*);
